// ----- rtl/core/stepper_position_settle_driver_defines.svh -----
// Assertion macros shared by the stepper settle driver RTL.
// Self-contained; included by files that carry concurrent assertions.
`ifndef STEPPER_POSITION_SETTLE_DRIVER_DEFINES_SVH
`define STEPPER_POSITION_SETTLE_DRIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/spsd_pkg.sv -----
// Package for the stepper settle driver: widths, register indexes, types
// and the half-step coil table. No dependencies.
package spsd_pkg;

	localparam int POS_W         = 3;
	localparam int PHASE_W       = 3;
	localparam int RUN_W         = 6;
	localparam int ADC_W         = 8;
	localparam int COIL_W        = 4;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 8;
	localparam int NUM_LEVELS    = 6;
	localparam int NUM_POSITIONS_DEF = 6;

	// Moves of more than this many positions go the other way round.
	localparam logic [POS_W-1:0] SHORT_WAY = 3'd3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_0   = 4'd2;

	// Reset values of the registers.
	localparam logic [ADC_W-1:0] TOLERANCE_RST = 8'd10;
	localparam logic [RUN_W-1:0] SETTLE_RST    = 6'd50;
	localparam logic [NUM_LEVELS-1:0][ADC_W-1:0] LEVELS_RST =
		{8'd255, 8'd187, 8'd139, 8'd102, 8'd69, 8'd37};

	typedef struct packed {
		logic [ADC_W-1:0]                  tolerance;
		logic [RUN_W-1:0]                  settle_needed;
		logic [NUM_LEVELS-1:0][ADC_W-1:0]  level;
	} cfg_t;

	typedef struct packed {
		logic             mode;
		logic [POS_W-1:0] target_position;
		logic [ADC_W-1:0] adc_sample;
	} item_t;

	typedef struct packed {
		logic [COIL_W-1:0] coil_pattern;
		logic              busy_res;
		logic              move_done;
		logic [POS_W-1:0]  position;
	} result_t;

	// Forward half-step sequence; reverse uses the complemented phase.
	function automatic logic [COIL_W-1:0] fwd_pattern(input logic [PHASE_W-1:0] p);
		logic [COIL_W-1:0] pat;
		case (p)
			3'd0:    pat = 4'h1;
			3'd1:    pat = 4'h3;
			3'd2:    pat = 4'h2;
			3'd3:    pat = 4'h6;
			3'd4:    pat = 4'h4;
			3'd5:    pat = 4'hC;
			3'd6:    pat = 4'h8;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

	function automatic logic [COIL_W-1:0] coil_for(input logic [PHASE_W-1:0] p,
		input logic rev);
		return fwd_pattern(rev ? ~p : p);
	endfunction

endpackage

// ----- rtl/core/spsd_cfg_regs.sv -----
// Configuration register file of the stepper settle driver.
// Depends on spsd_pkg for indexes, reset values and the cfg_t struct.
module spsd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [spsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output spsd_pkg::cfg_t                   cfg
);

	spsd_pkg::cfg_t cfg_q;

	// Register writes; indexes past the last level are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance     <= spsd_pkg::TOLERANCE_RST;
			cfg_q.settle_needed <= spsd_pkg::SETTLE_RST;
			cfg_q.level         <= spsd_pkg::LEVELS_RST;
		end else if (cfg_write) begin
			if (cfg_index == spsd_pkg::REG_TOLERANCE) begin
				cfg_q.tolerance <= cfg_data;
			end
			if (cfg_index == spsd_pkg::REG_SETTLE) begin
				cfg_q.settle_needed <= cfg_data[spsd_pkg::RUN_W-1:0];
			end
			for (int i = 0; i < spsd_pkg::NUM_LEVELS; i++) begin
				if (cfg_index == spsd_pkg::REG_LEVEL_0 + spsd_pkg::CFG_IDX_W'(i)) begin
					cfg_q.level[i] <= cfg_data;
				end
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/spsd_step_core.sv -----
// Move state and per-item step logic of the stepper settle driver.
// Depends on spsd_pkg for types, widths and the coil table.
module spsd_step_core #(
	parameter int NUM_POSITIONS = spsd_pkg::NUM_POSITIONS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  spsd_pkg::item_t  item,
	input  spsd_pkg::cfg_t   cfg,
	output spsd_pkg::result_t result
);

	localparam logic [spsd_pkg::POS_W:0] POS_LIMIT = (spsd_pkg::POS_W+1)'(NUM_POSITIONS);

	logic [spsd_pkg::POS_W-1:0]   pos_q,   pos_n;
	logic                         rev_q,   rev_n;
	logic [spsd_pkg::PHASE_W-1:0] phase_q, phase_n;
	logic [spsd_pkg::RUN_W-1:0]   run_q,   run_n;
	logic                         moving_q, moving_n;

	logic                         tgt_bad;
	logic                         tgt_above;
	logic [spsd_pkg::POS_W-1:0]   mag;
	logic [spsd_pkg::ADC_W-1:0]   level;
	logic [spsd_pkg::ADC_W:0]     diff;
	logic                         match;
	logic [spsd_pkg::RUN_W-1:0]   run_inc;

	// Expected level of the held position, zero where no register exists.
	always_comb begin
		if ({1'b0, pos_q} < (spsd_pkg::POS_W+1)'(spsd_pkg::NUM_LEVELS)) begin
			level = cfg.level[pos_q];
		end else begin
			level = '0;
		end
	end

	// Match test and run count for a tick.
	always_comb begin
		diff = {1'b0, level} - {1'b0, item.adc_sample};
		if (diff[spsd_pkg::ADC_W]) begin
			diff = -diff;
		end
		match   = diff < {1'b0, cfg.tolerance};
		run_inc = match ? run_q + 1'b1 : '0;
	end

	// Range check of the target, and direction of a new move from the distance to it.
	always_comb begin
		tgt_bad   = {1'b0, item.target_position} >= POS_LIMIT;
		tgt_above = item.target_position > pos_q;
		mag       = tgt_above ? item.target_position - pos_q : pos_q - item.target_position;
	end

	// Next state and the result of the item in stage one.
	always_comb begin
		pos_n    = pos_q;
		rev_n    = rev_q;
		phase_n  = phase_q;
		run_n    = run_q;
		moving_n = moving_q;
		result.coil_pattern = '0;
		result.move_done    = 1'b0;
		if (!item.mode) begin
			if (moving_q || tgt_bad) begin
				result.coil_pattern = moving_q ? spsd_pkg::coil_for(phase_q, rev_q) : '0;
			end else if (item.target_position == pos_q) begin
				result.move_done = 1'b1;
			end else begin
				rev_n    = tgt_above ? (mag <= spsd_pkg::SHORT_WAY) : (mag > spsd_pkg::SHORT_WAY);
				pos_n    = item.target_position;
				phase_n  = spsd_pkg::PHASE_W'(1);
				run_n    = '0;
				moving_n = 1'b1;
				result.coil_pattern = spsd_pkg::coil_for(phase_n, rev_n);
			end
		end else if (moving_q) begin
			if (run_inc >= cfg.settle_needed) begin
				moving_n = 1'b0;
				run_n    = '0;
				result.move_done = 1'b1;
			end else begin
				run_n   = run_inc;
				phase_n = phase_q + 1'b1;
				result.coil_pattern = spsd_pkg::coil_for(phase_n, rev_q);
			end
		end
		result.busy_res = moving_n;
		result.position = pos_n;
	end

	// Move state advances once per item leaving stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			rev_q    <= 1'b0;
			phase_q  <= '0;
			run_q    <= '0;
			moving_q <= 1'b0;
		end else if (advance) begin
			pos_q    <= pos_n;
			rev_q    <= rev_n;
			phase_q  <= phase_n;
			run_q    <= run_n;
			moving_q <= moving_n;
		end
	end

endmodule

// ----- rtl/core/stepper_position_settle_driver.sv -----
// Top level of the half-step stepper settle driver.
// Depends on spsd_pkg, spsd_cfg_regs, spsd_step_core and the defines header.
`include "stepper_position_settle_driver_defines.svh"

// Takes one request per clock cycle while the output side does not stall
// and returns one result per request: a request is captured in an input
// register, the step logic updates the move state from it as it leaves
// that register, and the result lands in an output register that holds
// while the output side stalls. The rate of one request per cycle is set by
// the move state, which every request reads and writes once as it advances.
// Configuration writes take effect at once and are meant for idle periods.
module stepper_position_settle_driver #(
	parameter int NUM_POSITIONS = spsd_pkg::NUM_POSITIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [spsd_pkg::POS_W-1:0]        target_position,
	input  logic [spsd_pkg::ADC_W-1:0]        adc_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spsd_pkg::COIL_W-1:0]       coil_pattern,
	output logic                              busy_res,
	output logic                              move_done,
	output logic [spsd_pkg::POS_W-1:0]        position,
	input  logic                              cfg_write,
	input  logic [spsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	spsd_pkg::cfg_t    cfg;
	spsd_pkg::item_t   item_s1;
	spsd_pkg::result_t result;
	spsd_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	spsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spsd_step_core #(
		.NUM_POSITIONS (NUM_POSITIONS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Stage one moves on whenever the output register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode            <= mode;
			item_s1.target_position <= target_position;
			item_s1.adc_sample      <= adc_sample;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign coil_pattern = res_s2.coil_pattern;
	assign busy_res     = res_s2.busy_res;
	assign move_done    = res_s2.move_done;
	assign position     = res_s2.position;

	// A finished or skipped move always leaves the coils released.
	`SPSD_ASSERT_IMP(a_done_released, clk, arst_n, out_valid && move_done, coil_pattern == '0, "move done with coils driven")
	// While moving, one or two coils are energized.
	`SPSD_ASSERT_IMP(a_busy_coils, clk, arst_n, out_valid && busy_res, ($countones(coil_pattern) == 1) || ($countones(coil_pattern) == 2), "bad coil pattern while moving")
	// A moving block holds a position in range.
	`SPSD_ASSERT_IMP(a_busy_pos, clk, arst_n, out_valid && busy_res, {1'b0, position} < (spsd_pkg::POS_W+1)'(NUM_POSITIONS), "position out of range while moving")
	// An empty output register never holds back a new request.
	`SPSD_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready, "request blocked with output free")

endmodule
